>>> design/rrs_pkg.sv
// ----------------------------------------------------------------------------
// rrs_pkg
// Shared constants, state encoding and controller/datapath bundles for the
// round-robin scheduler.
// ----------------------------------------------------------------------------
package rrs_pkg;

  localparam int unsigned MAX_PROCS = 16;
  localparam int unsigned IDX_W     = $clog2(MAX_PROCS);
  localparam int unsigned CNT_W     = $clog2(MAX_PROCS + 1);
  localparam int unsigned ARR_W     = 16;
  localparam int unsigned TIME_W    = 24;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_ADMIT,
    ST_DECIDE,
    ST_MIN,
    ST_MINSET,
    ST_RUN,
    ST_REQUEUE,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic load;
    logic scan_clr;
    logic scan_inc;
    logic admit;
    logic min_clr;
    logic min_step;
    logic min_apply;
    logic pop;
    logic run;
    logic requeue;
    logic emit;
    logic clear;
  } cmd_t;

  typedef struct packed {
    logic scan_last;
    logic ring_empty;
    logic all_done;
    logic out_free;
  } status_t;

endpackage

>>> design/rrs_ctrl.sv
// ----------------------------------------------------------------------------
// rrs_ctrl
// Sequencer for loading, admission scans, dispatch, idle jumps and result
// emission.
// ----------------------------------------------------------------------------
module rrs_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             last_item_i,
  output logic             in_stall_o,
  input  rrs_pkg::status_t status_i,
  output rrs_pkg::cmd_t    cmd_o
);
  import rrs_pkg::*;

  state_e state_q, state_d;
  state_e ret_q, ret_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      ret_q   <= ST_DECIDE;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    ret_d      = ret_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_LOAD: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (last_item_i) begin
            cmd_o.scan_clr = 1'b1;
            ret_d          = ST_DECIDE;
            state_d        = ST_ADMIT;
          end
        end
      end
      ST_ADMIT: begin
        cmd_o.admit    = 1'b1;
        cmd_o.scan_inc = 1'b1;
        if (status_i.scan_last) state_d = ret_q;
      end
      ST_DECIDE: begin
        if (status_i.all_done) begin
          cmd_o.scan_clr = 1'b1;
          state_d        = ST_EMIT;
        end else if (status_i.ring_empty) begin
          cmd_o.scan_clr = 1'b1;
          cmd_o.min_clr  = 1'b1;
          state_d        = ST_MIN;
        end else begin
          cmd_o.pop = 1'b1;
          state_d   = ST_RUN;
        end
      end
      ST_MIN: begin
        cmd_o.min_step = 1'b1;
        cmd_o.scan_inc = 1'b1;
        if (status_i.scan_last) state_d = ST_MINSET;
      end
      ST_MINSET: begin
        cmd_o.min_apply = 1'b1;
        cmd_o.scan_clr  = 1'b1;
        ret_d           = ST_DECIDE;
        state_d         = ST_ADMIT;
      end
      ST_RUN: begin
        cmd_o.run      = 1'b1;
        cmd_o.scan_clr = 1'b1;
        ret_d          = ST_REQUEUE;
        state_d        = ST_ADMIT;
      end
      ST_REQUEUE: begin
        cmd_o.requeue = 1'b1;
        state_d       = ST_DECIDE;
      end
      ST_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.emit     = 1'b1;
          cmd_o.scan_inc = 1'b1;
          if (status_i.scan_last) begin
            cmd_o.clear = 1'b1;
            state_d     = ST_LOAD;
          end
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

endmodule

>>> design/rrs_dpath.sv
// ----------------------------------------------------------------------------
// rrs_dpath
// Process tables, ready ring, clock of the simulation and output register.
// ----------------------------------------------------------------------------
module rrs_dpath (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  rrs_pkg::cmd_t               cmd_i,
  output rrs_pkg::status_t            status_o,
  input  logic                        cfg_we_i,
  input  logic [15:0]                 cfg_data_i,
  input  logic [rrs_pkg::ARR_W-1:0]   arrival_time_i,
  input  logic [rrs_pkg::ARR_W-1:0]   burst_length_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [rrs_pkg::IDX_W-1:0]   proc_index_o,
  output logic [rrs_pkg::TIME_W-1:0]  completion_time_o,
  output logic [rrs_pkg::TIME_W-1:0]  turnaround_time_o,
  output logic [rrs_pkg::TIME_W-1:0]  waiting_time_o,
  output logic [rrs_pkg::TIME_W-1:0]  response_time_o,
  output logic                        overflow_o,
  output logic                        last_result_o
);
  import rrs_pkg::*;

  logic [ARR_W-1:0]  arr_mem  [MAX_PROCS];
  logic [ARR_W-1:0]  bur_mem  [MAX_PROCS];
  logic [ARR_W-1:0]  rem_mem  [MAX_PROCS];
  logic [TIME_W-1:0] resp_mem [MAX_PROCS];
  logic [TIME_W-1:0] comp_mem [MAX_PROCS];
  logic [IDX_W-1:0]  ring_mem [MAX_PROCS];

  logic [15:0]          quantum_q;
  logic [MAX_PROCS-1:0] queued_q, done_q, resp_set_q;
  logic [IDX_W-1:0]     head_q, tail_q, p_q;
  logic [CNT_W-1:0]     ring_cnt_q, proc_cnt_q, fin_cnt_q, scan_q;
  logic [TIME_W-1:0]    time_q;
  logic [ARR_W-1:0]     best_q;
  logic                 found_q, dropped_q;

  logic                 out_valid_q;
  logic [IDX_W-1:0]     idx_q;
  logic [TIME_W-1:0]    comp_q, tat_q, wait_q, resp_q;
  logic                 ovf_q, last_q;

  logic [IDX_W-1:0]  scan_idx, rd_idx, push_val;
  logic [ARR_W-1:0]  arr_rd, bur_rd, rem_rd, q_eff, take;
  logic [TIME_W-1:0] arr_ext, comp_rd, tat, waitv;
  logic              admit_hit, push, full;

  assign scan_idx = scan_q[IDX_W-1:0];
  assign rd_idx   = (cmd_i.run || cmd_i.requeue) ? p_q : scan_idx;
  assign arr_rd   = arr_mem[rd_idx];
  assign bur_rd   = bur_mem[rd_idx];
  assign rem_rd   = rem_mem[rd_idx];
  assign comp_rd  = comp_mem[rd_idx];
  assign arr_ext  = {{(TIME_W-ARR_W){1'b0}}, arr_rd};

  assign q_eff = (quantum_q == '0) ? ARR_W'(1) : quantum_q;
  assign take  = (rem_rd < q_eff) ? rem_rd : q_eff;

  assign admit_hit = !done_q[scan_idx] && !queued_q[scan_idx] && (time_q >= arr_ext);
  assign push      = (cmd_i.admit && admit_hit) || (cmd_i.requeue && rem_rd != '0);
  assign push_val  = cmd_i.admit ? scan_idx : p_q;
  assign full      = (proc_cnt_q == CNT_W'(MAX_PROCS));

  assign tat   = comp_rd - arr_ext;
  assign waitv = tat - {{(TIME_W-ARR_W){1'b0}}, bur_rd};

  assign status_o.scan_last  = (scan_q == proc_cnt_q - CNT_W'(1));
  assign status_o.ring_empty = (ring_cnt_q == '0);
  assign status_o.all_done   = (fin_cnt_q == proc_cnt_q);
  assign status_o.out_free   = !out_valid_q || !out_stall_i;

  // tables, no reset
  always_ff @(posedge clk_i) begin
    if (cmd_i.load && !full) begin
      arr_mem[proc_cnt_q[IDX_W-1:0]] <= arrival_time_i;
      bur_mem[proc_cnt_q[IDX_W-1:0]] <= burst_length_i;
      rem_mem[proc_cnt_q[IDX_W-1:0]] <= burst_length_i;
    end
    if (cmd_i.run) begin
      rem_mem[p_q] <= rem_rd - take;
      if (!resp_set_q[p_q]) resp_mem[p_q] <= time_q - arr_ext;
    end
    if (cmd_i.requeue && rem_rd == '0) comp_mem[p_q] <= time_q;
    if (push) ring_mem[tail_q] <= push_val;
    if (cmd_i.pop) p_q <= ring_mem[head_q];
    if (cmd_i.emit) begin
      idx_q  <= scan_idx;
      comp_q <= comp_rd;
      tat_q  <= tat;
      wait_q <= waitv;
      resp_q <= resp_mem[scan_idx];
      ovf_q  <= dropped_q;
      last_q <= status_o.scan_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quantum_q   <= 16'd4;
      queued_q    <= '0;
      done_q      <= '0;
      resp_set_q  <= '0;
      head_q      <= '0;
      tail_q      <= '0;
      ring_cnt_q  <= '0;
      proc_cnt_q  <= '0;
      fin_cnt_q   <= '0;
      scan_q      <= '0;
      time_q      <= '0;
      best_q      <= '0;
      found_q     <= 1'b0;
      dropped_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) quantum_q <= cfg_data_i;
      if (cmd_i.load) begin
        if (!full) proc_cnt_q <= proc_cnt_q + CNT_W'(1);
        else       dropped_q  <= 1'b1;
      end
      if (cmd_i.scan_clr)      scan_q <= '0;
      else if (cmd_i.scan_inc) scan_q <= scan_q + CNT_W'(1);

      // ring pointers, push and pop never share a cycle
      if (push) begin
        tail_q     <= (tail_q == IDX_W'(MAX_PROCS-1)) ? '0 : tail_q + IDX_W'(1);
        ring_cnt_q <= ring_cnt_q + CNT_W'(1);
      end else if (cmd_i.pop) begin
        head_q     <= (head_q == IDX_W'(MAX_PROCS-1)) ? '0 : head_q + IDX_W'(1);
        ring_cnt_q <= ring_cnt_q - CNT_W'(1);
      end
      if (cmd_i.admit && admit_hit) queued_q[scan_idx] <= 1'b1;

      if (cmd_i.min_clr) found_q <= 1'b0;
      if (cmd_i.min_step && !queued_q[scan_idx] && (!found_q || arr_rd < best_q)) begin
        best_q  <= arr_rd;
        found_q <= 1'b1;
      end
      if (cmd_i.min_apply && found_q && {{(TIME_W-ARR_W){1'b0}}, best_q} > time_q)
        time_q <= {{(TIME_W-ARR_W){1'b0}}, best_q};

      if (cmd_i.run) begin
        time_q           <= time_q + {{(TIME_W-ARR_W){1'b0}}, take};
        resp_set_q[p_q]  <= 1'b1;
      end
      if (cmd_i.requeue && rem_rd == '0) begin
        done_q[p_q] <= 1'b1;
        fin_cnt_q   <= fin_cnt_q + CNT_W'(1);
      end

      if (cmd_i.emit)       out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;

      if (cmd_i.clear) begin
        queued_q   <= '0;
        done_q     <= '0;
        resp_set_q <= '0;
        head_q     <= '0;
        tail_q     <= '0;
        ring_cnt_q <= '0;
        proc_cnt_q <= '0;
        fin_cnt_q  <= '0;
        time_q     <= '0;
        dropped_q  <= 1'b0;
      end
    end
  end

  assign out_valid_o       = out_valid_q;
  assign proc_index_o      = idx_q;
  assign completion_time_o = comp_q;
  assign turnaround_time_o = tat_q;
  assign waiting_time_o    = wait_q;
  assign response_time_o   = resp_q;
  assign overflow_o        = ovf_q;
  assign last_result_o     = last_q;

  a_ring_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ring_cnt_q <= CNT_W'(MAX_PROCS))
    else $error("ready ring count above capacity");
  a_fin_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_cnt_q <= proc_cnt_q)
    else $error("more finished than loaded");
  a_done_queued: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q & ~queued_q) == '0)
    else $error("process finished without being admitted");
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.pop |-> ring_cnt_q != '0)
    else $error("pop from empty ready ring");

endmodule

>>> design/round_robin_scheduler_sim.sv
// ----------------------------------------------------------------------------
// round_robin_scheduler_sim
// Loads a set of processes, simulates round-robin scheduling with a FIFO
// ready queue and emits per-process timing results in load order.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                word
//  in        input      in_valid_i / in_stall_o  arrival, burst, last flag
//  out       output     out_valid_o / out_stall_i per-process timing result
//  cfg       input      cfg_we_i                 time quantum
//
// loading takes one word per cycle; the word with last_item starts the run
// each time slice is dominated by the one-entry-per-cycle admission scan over
// the n loaded processes; an idle jump scans for the minimum arrival first
// results leave at one per cycle after the run unless out_stall_i holds them;
// input is stalled from the last word until the final result is in the output
// register; reset is asynchronous, active low, and sets the quantum to 4
module round_robin_scheduler_sim (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [15:0]                 cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [rrs_pkg::ARR_W-1:0]   arrival_time_i,
  input  logic [rrs_pkg::ARR_W-1:0]   burst_length_i,
  input  logic                        last_item_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [rrs_pkg::IDX_W-1:0]   proc_index_o,
  output logic [rrs_pkg::TIME_W-1:0]  completion_time_o,
  output logic [rrs_pkg::TIME_W-1:0]  turnaround_time_o,
  output logic [rrs_pkg::TIME_W-1:0]  waiting_time_o,
  output logic [rrs_pkg::TIME_W-1:0]  response_time_o,
  output logic                        overflow_o,
  output logic                        last_result_o
);
  import rrs_pkg::*;

  cmd_t    cmd;
  status_t status;

  rrs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .last_item_i (last_item_i),
    .in_stall_o  (in_stall_o),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  rrs_dpath u_dpath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .status_o          (status),
    .cfg_we_i          (cfg_we_i),
    .cfg_data_i        (cfg_data_i),
    .arrival_time_i    (arrival_time_i),
    .burst_length_i    (burst_length_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .proc_index_o      (proc_index_o),
    .completion_time_o (completion_time_o),
    .turnaround_time_o (turnaround_time_o),
    .waiting_time_o    (waiting_time_o),
    .response_time_o   (response_time_o),
    .overflow_o        (overflow_o),
    .last_result_o     (last_result_o)
  );

endmodule
